FILE: design/assert_macros.svh
// Assertion macros used by the point weld table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define PWT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising clk edge, reset included.
`define PWT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/pwt_pkg.sv
// Shared types and constants of the point weld table.
package pwt_pkg;

	localparam int unsigned PWT_DEPTH = 256;
	localparam logic [31:0] PWT_WELD_RESET = 32'd65536;
	localparam logic [15:0] PWT_USES_MAX = 16'hFFFF;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
	} pwt_pos_t;

	typedef struct packed {
		pwt_pos_t    pos;
		logic [15:0] radius;
		logic [15:0] angle;
		logic [15:0] uses;
	} pwt_entry_t;

	typedef enum logic [1:0] {
		PWT_IDLE,
		PWT_SCAN,
		PWT_FINISH
	} pwt_state_t;

endpackage

FILE: design/pwt_ifs.sv
// Handshake channels of the point weld table: point in, result out, config write.

interface pwt_point_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [23:0] pos_z;
	logic [15:0]        point_radius;
	logic [15:0]        point_angle;

	modport source (output valid, pos_x, pos_y, pos_z, point_radius, point_angle,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, point_radius, point_angle,
		output ready);
endinterface

interface pwt_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] entry_index;
	logic       was_added;
	logic       table_full;

	modport source (output valid, entry_index, was_added, table_full, input ready);
	modport sink (input valid, entry_index, was_added, table_full, output ready);
endinterface

interface pwt_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] weld_distance_sq;

	modport source (output valid, weld_distance_sq, input ready);
	modport sink (input valid, weld_distance_sq, output ready);
endinterface

FILE: design/pwt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module pwt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/pwt_dist.sv
// Squared distance unit: registered per-axis squares, then saturating sum and compare.
module pwt_dist (
	input  logic               clk,
	input  pwt_pkg::pwt_pos_t  point,
	input  pwt_pkg::pwt_pos_t  stored,
	input  logic [31:0]        threshold,
	output logic               dist_lt
);
	import pwt_pkg::*;

	logic [24:0] diff [3];
	logic [24:0] mag  [3];
	logic [49:0] sq_s2 [3];
	logic [51:0] sum;
	logic [31:0] dist_sat;

	always_comb begin
		diff[0] = {point.x[23], point.x} - {stored.x[23], stored.x};
		diff[1] = {point.y[23], point.y} - {stored.y[23], stored.y};
		diff[2] = {point.z[23], point.z} - {stored.z[23], stored.z};
		for (int k = 0; k < 3; k++) begin
			// magnitude is at most 2^24-1 and fits 25 bits unsigned
			mag[k] = diff[k][24] ? 25'(-diff[k]) : diff[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sq_s2[k] <= 50'(mag[k]) * 50'(mag[k]);
		end
	end

	always_comb begin
		sum      = 52'(sq_s2[0]) + 52'(sq_s2[1]) + 52'(sq_s2[2]);
		dist_sat = (|sum[51:32]) ? 32'hFFFF_FFFF : sum[31:0];
		dist_lt  = dist_sat < threshold;
	end

endmodule

FILE: design/point_weld_table.sv
// Top level of the point weld table: scan sequencer, entry RAM and merge logic.
//
// Point weld table. Each point request (x, y, z, radius, angle) is compared
// against the stored entries in insertion order; the first entry whose
// squared distance lies strictly below weld_distance_sq (Q16, reset 1.0)
// absorbs the point: it keeps the larger radius and angle, its use count
// goes up (saturating at 65535) and its index is returned with
// was_added = 0. Without a match the point is appended with use count 1
// and was_added = 1, or, with all TABLE_DEPTH entries taken, the result
// reports table_full = 1 with index 0 and the table is left alone.
// Squared distances saturate at 2^32-1 and a saturated distance never
// matches. Only reset empties the table; no clearing pass is needed since
// only entries below the fill count are read.
// Timing: one point at a time. A point that hits entry i ends its scan at
// that entry; a point that misses scans every filled entry. A result
// still held in the output register delays the write-back and the next
// result until the sink takes it. The scan reads the entries through the
// single RAM read port, one entry per cycle until a hit stops the reads,
// into the two-stage distance pipeline. The next point is taken
// while a result still waits in the output register. The config channel
// is always ready; write it only while no point is in flight.
`include "assert_macros.svh"

module point_weld_table #(
	parameter int unsigned TABLE_DEPTH = pwt_pkg::PWT_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	pwt_point_if.sink    point,
	pwt_result_if.source result,
	pwt_cfg_if.sink      cfg
);
	import pwt_pkg::*;

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	pwt_state_t state_q, state_d;

	// weld threshold
	logic [31:0] thr_q;

	// fill count and scan issue pointer
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] issue_q;

	// request under work
	pwt_pos_t    pt_q;
	logic [15:0] rad_q;
	logic [15:0] ang_q;

	// scan pipeline: s1 = RAM data out, s2 = squares registered
	logic             v_s1, v_s2;
	logic [IDX_W-1:0] idx_s1, idx_s2;
	pwt_entry_t       ent_s1, ent_s2;

	// pending write-back and result
	logic             fin_we_q;
	logic             fin_add_q;
	logic             fin_full_q;
	logic [IDX_W-1:0] fin_addr_q;
	pwt_entry_t       fin_data_q;

	// output register
	logic       res_valid_q;
	logic [7:0] res_index_q;
	logic       res_added_q;
	logic       res_full_q;

	// control
	logic       rd_en;
	logic       dist_lt;
	logic       hit;
	logic       scan_done;
	logic       slot_free;
	logic       finish;
	logic       ram_we;
	logic       accept;
	logic       table_is_full;
	pwt_entry_t merged;
	pwt_entry_t fresh;

	// ---------------------------------------------------------------
	// Entry storage
	// ---------------------------------------------------------------
	pwt_ram #(
		.WIDTH ($bits(pwt_entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fin_addr_q),
		.wdata (fin_data_q),
		.re    (rd_en),
		.raddr (issue_q[IDX_W-1:0]),
		.rdata (ent_s1)
	);

	// distance of the s1 entry to the current point, compare at s2
	pwt_dist u_dist (
		.clk       (clk),
		.point     (pt_q),
		.stored    (ent_s1.pos),
		.threshold (thr_q),
		.dist_lt   (dist_lt)
	);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PWT_IDLE: begin
				if (point.valid) begin
					state_d = PWT_SCAN;
				end
			end
			PWT_SCAN: begin
				if (hit || scan_done) begin
					state_d = PWT_FINISH;
				end
			end
			PWT_FINISH: begin
				if (slot_free) begin
					state_d = PWT_IDLE;
				end
			end
			default: state_d = PWT_IDLE;
		endcase
	end

	always_comb begin
		hit           = v_s2 && dist_lt;
		scan_done     = (issue_q == fill_q) && !v_s1 && !v_s2;
		slot_free     = !res_valid_q || result.ready;
		accept        = (state_q == PWT_IDLE) && point.valid;
		rd_en         = (state_q == PWT_SCAN) && (issue_q < fill_q) && !hit;
		finish        = (state_q == PWT_FINISH) && slot_free;
		ram_we        = finish && fin_we_q;
		table_is_full = fill_q == CNT_W'(TABLE_DEPTH);
		point.ready   = state_q == PWT_IDLE;
		cfg.ready     = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PWT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------
	// Config register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= PWT_WELD_RESET;
		end else if (cfg.valid) begin
			thr_q <= cfg.weld_distance_sq;
		end
	end

	// ---------------------------------------------------------------
	// Fill count, issue pointer, pipeline valids
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			issue_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (accept) begin
				issue_q <= '0;
			end else if (rd_en) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			// a hit flushes the reads already in flight
			if (hit) begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
			end else begin
				v_s1 <= rd_en;
				v_s2 <= v_s1;
			end
			if (finish && fin_add_q) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Datapath registers
	// ---------------------------------------------------------------
	always_comb begin
		merged        = ent_s2;
		merged.radius = (rad_q > ent_s2.radius) ? rad_q : ent_s2.radius;
		merged.angle  = (ang_q > ent_s2.angle) ? ang_q : ent_s2.angle;
		merged.uses   = (ent_s2.uses != PWT_USES_MAX) ? ent_s2.uses + 16'd1 : ent_s2.uses;

		fresh.pos    = pt_q;
		fresh.radius = rad_q;
		fresh.angle  = ang_q;
		fresh.uses   = 16'd1;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pt_q.x <= point.pos_x;
			pt_q.y <= point.pos_y;
			pt_q.z <= point.pos_z;
			rad_q  <= point.point_radius;
			ang_q  <= point.point_angle;
		end
		idx_s1 <= issue_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		ent_s2 <= ent_s1;
		if (state_q == PWT_SCAN) begin
			priority if (hit) begin
				fin_we_q   <= 1'b1;
				fin_add_q  <= 1'b0;
				fin_full_q <= 1'b0;
				fin_addr_q <= idx_s2;
				fin_data_q <= merged;
			end else if (scan_done) begin
				fin_we_q   <= !table_is_full;
				fin_add_q  <= !table_is_full;
				fin_full_q <= table_is_full;
				fin_addr_q <= fill_q[IDX_W-1:0];
				fin_data_q <= fresh;
			end
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (finish) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			// full: index reads 0
			res_index_q <= fin_full_q ? 8'd0 : 8'(fin_addr_q);
			res_added_q <= fin_add_q;
			res_full_q  <= fin_full_q;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.entry_index = res_index_q;
	assign result.was_added   = res_added_q;
	assign result.table_full  = res_full_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`PWT_ASSERT(a_fill_bound, fill_q <= CNT_W'(TABLE_DEPTH), "fill count beyond table depth")
	`PWT_ASSERT(a_write_in_range, ram_we |-> (CNT_W'(fin_addr_q) <= fill_q),
		"write-back beyond the fill count")
	`PWT_ASSERT(a_flags_exclusive, result.valid |-> !(result.was_added && result.table_full),
		"result both added and full")
	`PWT_ASSERT(a_append_grows, (finish && fin_add_q) |=> (fill_q == $past(fill_q) + CNT_W'(1)),
		"append did not advance the fill count")

endmodule
